// ----- hw/rtl/assert_macros.svh -----
// Concurrent assertion helpers; both expect clk and rst_n in scope.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

`ifndef SYNTHESIS

`define ASSERT_CLK(label, prop) \
  label: assert property (@(posedge clk) disable iff (!rst_n) prop) \
    else $error("assertion failed");

`define ASSERT_NEVER(label, cond) \
  label: assert property (@(posedge clk) disable iff (!rst_n) !(cond)) \
    else $error("forbidden condition seen");

`else

`define ASSERT_CLK(label, prop)

`define ASSERT_NEVER(label, cond)

`endif

`endif

// ----- hw/rtl/hcbp_pkg.sv -----
package hcbp_pkg;

  localparam int KIND_W       = 2;
  localparam int BYTE_W       = 8;
  localparam int CODE_W       = 32;
  localparam int MAX_CODE_LEN = 31;
  localparam int LEN_W        = 5;
  localparam int SYM_W        = 8;
  localparam int MAX_BYTES    = 4;
  localparam int CNT_W        = 3;
  localparam int BC_W         = 3;
  localparam int TOT_W        = 6;
  // pending bits plus the longest code
  localparam int ACC_W        = (BYTE_W - 1) + MAX_CODE_LEN;
  localparam int BUF_W        = MAX_BYTES * BYTE_W;

  typedef enum logic [KIND_W-1:0] {
    KIND_LOAD   = 2'd0,
    KIND_ENCODE = 2'd1,
    KIND_FLUSH  = 2'd2
  } kind_t;

  typedef struct packed {
    logic [KIND_W-1:0]       kind;
    logic [LEN_W-1:0]        len;
    logic [MAX_CODE_LEN-1:0] code;
  } code_stage_t;

  // position of the highest set bit, zero when none above bit 0
  function automatic logic [LEN_W-1:0] lead_one(input logic [CODE_W-1:0] w);
    logic [LEN_W-1:0] p;
    p = '0;
    for (int i = 1; i < CODE_W; i++) begin
      if (w[i]) p = LEN_W'(i);
    end
    return p;
  endfunction

  function automatic logic [CODE_W-1:0] bit_rev(input logic [CODE_W-1:0] w);
    logic [CODE_W-1:0] r;
    for (int i = 0; i < CODE_W; i++) begin
      r[i] = w[CODE_W-1-i];
    end
    return r;
  endfunction

endpackage

// ----- hw/rtl/hcbp_in_if.sv -----
interface hcbp_in_if
  import hcbp_pkg::*;
();
  logic                  valid;
  logic                  ready;
  logic [KIND_W-1:0]     kind;
  logic [SYM_W-1:0]      symbol;
  logic [CODE_W-1:0]     code_word;

  modport source (output valid, kind, symbol, code_word, input ready);
  modport sink   (input valid, kind, symbol, code_word, output ready);
endinterface

// ----- hw/rtl/hcbp_out_if.sv -----
interface hcbp_out_if
  import hcbp_pkg::*;
();
  logic              valid;
  logic              ready;
  logic [BYTE_W-1:0] out_byte;
  logic              last_byte;

  modport source (output valid, out_byte, last_byte, input ready);
  modport sink   (input valid, out_byte, last_byte, output ready);
endinterface

// ----- hw/rtl/huffman_code_bit_packer.sv -----
// Huffman code bit packer: code table lookup and byte packing.
// Path to the first result byte: stage 1 table read, stage 2 code, result buffer.
// Throughput: one item per cycle while items yield at most one byte and the output is
// ready; an item of N bytes (up to 4) holds the output register until all are out.
// Reset: synchronous, active low; clears table valid bits, pending byte and count.
`include "assert_macros.svh"

module huffman_code_bit_packer
  import hcbp_pkg::*;
#(
  parameter int SYMBOLS = 256
) (
  input  logic              clk,
  input  logic              rst_n,
  hcbp_in_if.sink           in_ch,
  hcbp_out_if.source        out_ch
);

  localparam int AW = $clog2(SYMBOLS);

  // code table
  logic [CODE_W-1:0] mem [SYMBOLS];
  logic [SYMBOLS-1:0] tbl_vld_r;

  // stage 1: registered table read
  logic              s1_v_r;
  logic [KIND_W-1:0] s1_kind_r;
  logic [CODE_W-1:0] s1_word_r;
  logic              s1_hit_r;

  // stage 2: extracted code
  logic        s2_v_r;
  code_stage_t s2_r, s2_nxt;

  // pack state and result buffer
  logic [BYTE_W-1:0] pend_r, pend_nxt;
  logic [BC_W-1:0]   bc_r, bc_nxt;
  logic [BUF_W-1:0]  buf_r, buf_nxt;
  logic [CNT_W-1:0]  cnt_r, cnt_nxt;

  logic in_xfer, out_xfer, s3_take, s2_free, s1_free;
  logic in_range;
  logic [AW-1:0] idx;

  assign in_range = (9'(in_ch.symbol) < 9'(SYMBOLS));
  assign idx      = in_ch.symbol[AW-1:0];

  assign out_xfer = out_ch.valid && out_ch.ready;
  assign s3_take  = s2_v_r && ((cnt_r == '0) || ((cnt_r == CNT_W'(1)) && out_ch.ready));
  assign s2_free  = !s2_v_r || s3_take;
  assign s1_free  = !s1_v_r || s2_free;
  assign in_ch.ready = s1_free;
  assign in_xfer  = in_ch.valid && in_ch.ready;

  always_ff @(posedge clk) begin
    if (in_xfer && in_ch.kind == KIND_LOAD && in_range) mem[idx] <= in_ch.code_word;
    if (in_xfer) begin
      s1_word_r <= mem[idx];
      s1_hit_r  <= in_range && tbl_vld_r[idx];
      s1_kind_r <= in_ch.kind;
    end
  end

  // stage 1 -> stage 2: marker search and code alignment
  logic [CODE_W-1:0] w_eff, code_full;
  logic [LEN_W-1:0]  mpos, len;

  always_comb begin
    w_eff     = s1_hit_r ? s1_word_r : '0;
    mpos      = lead_one(w_eff);
    len       = ((w_eff > CODE_W'(1)) && ({1'b0, mpos} <= 6'(MAX_CODE_LEN))) ? mpos : '0;
    code_full = bit_rev(w_eff) >> (6'(CODE_W) - {1'b0, len});
    s2_nxt.kind = s1_kind_r;
    s2_nxt.len  = len;
    s2_nxt.code = (len == '0) ? '0 : code_full[MAX_CODE_LEN-1:0];
  end

  // stage 2 -> result buffer: merge with pending bits
  logic [ACC_W-1:0] acc;
  logic [TOT_W-1:0] tot;
  logic [CNT_W-1:0] nb;

  always_comb begin
    acc      = (ACC_W'(s2_r.code) << bc_r) | ACC_W'(pend_r);
    tot      = TOT_W'(bc_r) + TOT_W'(s2_r.len);
    nb       = tot[TOT_W-1:BC_W];
    pend_nxt = pend_r;
    bc_nxt   = bc_r;
    buf_nxt  = buf_r;
    cnt_nxt  = cnt_r;
    if (out_xfer) begin
      buf_nxt = buf_r >> BYTE_W;
      cnt_nxt = cnt_r - CNT_W'(1);
    end
    if (s3_take) begin
      case (s2_r.kind)
        KIND_ENCODE: begin
          buf_nxt  = acc[BUF_W-1:0];
          cnt_nxt  = nb;
          pend_nxt = BYTE_W'(acc >> {nb, 3'b000});
          bc_nxt   = tot[BC_W-1:0];
        end
        KIND_FLUSH: begin
          buf_nxt  = BUF_W'(pend_r);
          cnt_nxt  = CNT_W'(1);
          pend_nxt = '0;
          bc_nxt   = '0;
        end
        default: begin
          cnt_nxt = '0;
        end
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (s1_v_r && s2_free) s2_r <= s2_nxt;
    buf_r <= buf_nxt;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      tbl_vld_r <= '0;
      s1_v_r    <= 1'b0;
      s2_v_r    <= 1'b0;
      pend_r    <= '0;
      bc_r      <= '0;
      cnt_r     <= '0;
    end else begin
      if (in_xfer && in_ch.kind == KIND_LOAD && in_range) tbl_vld_r[idx] <= 1'b1;
      if (s1_free) s1_v_r <= in_xfer;
      if (s2_free) s2_v_r <= s1_v_r;
      pend_r <= pend_nxt;
      bc_r   <= bc_nxt;
      cnt_r  <= cnt_nxt;
    end
  end

  assign out_ch.valid     = (cnt_r != '0);
  assign out_ch.out_byte  = buf_r[BYTE_W-1:0];
  assign out_ch.last_byte = (cnt_r == CNT_W'(1));

  `ASSERT_NEVER(a_cnt_max, cnt_r > CNT_W'(MAX_BYTES))
  `ASSERT_NEVER(a_take_busy, s3_take && cnt_r > CNT_W'(1))
  `ASSERT_CLK(a_flush_clr, (s3_take && s2_r.kind == KIND_FLUSH) |=> (bc_r == '0 && pend_r == '0))
  `ASSERT_CLK(a_empty_code, (s3_take && s2_r.kind == KIND_ENCODE && s2_r.len == '0) |=> $stable(bc_r))

endmodule

// ----- verif/tb_top.sv -----
`timescale 1ns / 100ps

module tb_top
  import hcbp_pkg::*;
();

  localparam logic [KIND_W-1:0] KIND_UNUSED = 2'd3;
  localparam int TABLE_DEPTH    = 256;
  localparam int SETTLE_CYCLES  = 8;
  localparam int WATCHDOG_LIMIT = 1000;
  localparam int HOLDOFF_CYCLES = 150;

  typedef struct {
    logic [BYTE_W-1:0] data;
    logic              last;
  } packed_byte_t;

  logic clk = 1'b0;
  logic rst_n;

  hcbp_in_if  in_ch ();
  hcbp_out_if out_ch ();

  huffman_code_bit_packer #(.SYMBOLS(TABLE_DEPTH)) dut (
    .clk    (clk),
    .rst_n  (rst_n),
    .in_ch  (in_ch),
    .out_ch (out_ch)
  );

  always #5 clk = ~clk;

  // shadow copy of the block state
  logic [CODE_W-1:0] code_words [TABLE_DEPTH] = '{default: '0};
  logic [BYTE_W-1:0] pend_byte = '0;
  int                pend_bits = 0;

  packed_byte_t expected_bytes [$];

  int  fail_count    = 0;
  int  bytes_checked = 0;
  int  n_loads       = 0;
  int  n_encodes     = 0;
  int  n_flushes     = 0;
  int  n_ignored     = 0;
  bit  src_gap_en    = 1'b1;
  bit  sink_stall_en = 1'b1;
  bit  hold_req      = 1'b0;
  int  hold_len      = 0;
  int  idle_cycles   = 0;

  function automatic int pick_gap(input bit en);
    int r;
    r = $urandom_range(0, 99);
    if (!en || r < 60) return 0;
    if (r < 92) return $urandom_range(1, 3);
    return $urandom_range(10, 40);
  endfunction

  function automatic int pick_len();
    if ($urandom_range(0, 99) < 80) return $urandom_range(1, 10);
    return $urandom_range(11, MAX_CODE_LEN);
  endfunction

  // code word with random code bits under the length marker
  function automatic logic [CODE_W-1:0] make_code(input int len);
    logic [CODE_W-1:0] c;
    c = $urandom;
    c = c & ((32'h1 << len) - 32'h1);
    c[len] = 1'b1;
    return c;
  endfunction

  task automatic predict_packed_bytes(input logic [KIND_W-1:0] kind,
                                      input logic [SYM_W-1:0] sym,
                                      input logic [CODE_W-1:0] cw);
    packed_byte_t      burst [$];
    packed_byte_t      b;
    logic [CODE_W-1:0] w;
    int                top;
    case (kind)
      KIND_LOAD: begin
        code_words[sym] = cw;
      end
      KIND_ENCODE: begin
        w = code_words[sym];
        top = 0;
        for (int i = CODE_W - 1; i > 0 && top == 0; i--) begin
          if (w[i]) top = i;
        end
        // marker above the longest code length means no bits
        if (top > MAX_CODE_LEN) top = 0;
        for (int i = top - 1; i >= 0; i--) begin
          if (w[i]) pend_byte[pend_bits] = 1'b1;
          pend_bits++;
          if (pend_bits == BYTE_W) begin
            b.data = pend_byte;
            b.last = 1'b0;
            burst.push_back(b);
            pend_byte = '0;
            pend_bits = 0;
          end
        end
        if (burst.size() > 0) burst[burst.size() - 1].last = 1'b1;
        foreach (burst[i]) expected_bytes.push_back(burst[i]);
      end
      KIND_FLUSH: begin
        b.data = pend_byte;
        b.last = 1'b1;
        expected_bytes.push_back(b);
        pend_byte = '0;
        pend_bits = 0;
      end
      default: ;
    endcase
  endtask

  // Called in the step of the previous transfer; valid stays high on return.
  task automatic send_item(input logic [KIND_W-1:0] kind,
                           input logic [SYM_W-1:0] sym,
                           input logic [CODE_W-1:0] cw);
    int gap;
    gap = pick_gap(src_gap_en);
    if (gap > 0) begin
      in_ch.valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_ch.valid     <= 1'b1;
    in_ch.kind      <= kind;
    in_ch.symbol    <= sym;
    in_ch.code_word <= cw;
    do @(posedge clk); while (!in_ch.ready);
    predict_packed_bytes(kind, sym, cw);
    case (kind)
      KIND_LOAD:   n_loads++;
      KIND_ENCODE: n_encodes++;
      KIND_FLUSH:  n_flushes++;
      default:     n_ignored++;
    endcase
  endtask

  task automatic wait_for_outputs();
    in_ch.valid <= 1'b0;
    @(posedge clk);
    while (expected_bytes.size() != 0) @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  // unwritten entries are empty; flush of nothing gives a zero byte
  task automatic test_reset_state();
    send_item(KIND_ENCODE, 8'h00, '0);
    send_item(KIND_ENCODE, 8'hFF, '0);
    send_item(KIND_FLUSH, 8'h00, '0);
    send_item(KIND_UNUSED, 8'hA5, 32'hFFFF_FFFF);
    wait_for_outputs();
  endtask

  task automatic test_edge_codes();
    send_item(KIND_LOAD, 8'h00, 32'h0000_0000);
    send_item(KIND_LOAD, 8'hFF, 32'h0000_0001);
    send_item(KIND_ENCODE, 8'h00, '0);
    send_item(KIND_ENCODE, 8'hFF, '0);
    send_item(KIND_LOAD, 8'h02, 32'h0000_0002);
    send_item(KIND_LOAD, 8'h03, 32'h0000_0003);
    send_item(KIND_LOAD, 8'h04, 32'hFFFF_FFFF);
    send_item(KIND_LOAD, 8'h05, 32'h8000_0000);
    send_item(KIND_LOAD, 8'h06, 32'h0000_00FF);
    send_item(KIND_LOAD, 8'h07, 32'h0000_01A5);
    // 7 pending bits plus a 31-bit code: four bytes from one item
    send_item(KIND_ENCODE, 8'h06, '0);
    send_item(KIND_ENCODE, 8'h04, '0);
    send_item(KIND_ENCODE, 8'h05, '0);
    send_item(KIND_UNUSED, 8'h5A, 32'h0000_0000);
    send_item(KIND_ENCODE, 8'h03, '0);
    send_item(KIND_ENCODE, 8'h02, '0);
    send_item(KIND_ENCODE, 8'h07, '0);
    send_item(KIND_FLUSH, 8'h00, '0);
    send_item(KIND_FLUSH, 8'hFF, 32'hFFFF_FFFF);
    wait_for_outputs();
  endtask

  // output stalls long enough for the block to back up into its input
  task automatic test_output_holdoff();
    src_gap_en    = 1'b0;
    sink_stall_en = 1'b0;
    send_item(KIND_LOAD, 8'h11, make_code(MAX_CODE_LEN));
    send_item(KIND_LOAD, 8'h22, make_code(13));
    hold_len = HOLDOFF_CYCLES;
    hold_req = 1'b1;
    for (int i = 0; i < 16; i++) begin
      send_item(KIND_ENCODE, (i % 2) ? 8'h22 : 8'h11, '0);
    end
    send_item(KIND_FLUSH, 8'h00, '0);
    wait_for_outputs();
    src_gap_en    = 1'b1;
    sink_stall_en = 1'b1;
  endtask

  task automatic test_random_traffic();
    logic [SYM_W-1:0] pool [16];
    int               sent;
    int               r;
    bit               paused;
    sent   = 0;
    paused = 1'b0;
    foreach (pool[i]) begin
      pool[i] = SYM_W'($urandom_range(0, TABLE_DEPTH - 1));
      send_item(KIND_LOAD, pool[i], make_code(pick_len()));
      sent++;
    end
    while (sent < 95) begin
      r = $urandom_range(0, 99);
      if (r < 4) begin
        send_item(KIND_UNUSED, SYM_W'($urandom), $urandom);
      end else begin
        sent++;
        if (sent % 20 == 0) begin
          src_gap_en    = $urandom_range(0, 3) != 0;
          sink_stall_en = $urandom_range(0, 3) != 0;
        end
        if (r < 14) begin
          send_item(KIND_LOAD, pool[$urandom_range(0, 15)], make_code(pick_len()));
        end else if (r < 18) begin
          send_item(KIND_LOAD, SYM_W'($urandom), $urandom);
        end else if (r < 25) begin
          send_item(KIND_FLUSH, SYM_W'($urandom), $urandom);
        end else if (r < 90) begin
          send_item(KIND_ENCODE, pool[$urandom_range(0, 15)], $urandom);
        end else begin
          send_item(KIND_ENCODE, SYM_W'($urandom), $urandom);
        end
      end
      // sender stops until the output side is fully drained
      if (!paused && sent >= 55) begin
        paused = 1'b1;
        wait_for_outputs();
      end
    end
    send_item(KIND_FLUSH, 8'h00, '0);
    wait_for_outputs();
  endtask

  initial begin : sink_ready
    int stall_left;
    stall_left = 0;
    out_ch.ready <= 1'b0;
    forever begin
      @(posedge clk);
      if (hold_req) begin
        stall_left = hold_len;
        hold_req   = 1'b0;
      end else if (stall_left == 0 && sink_stall_en && $urandom_range(0, 99) < 25) begin
        stall_left = ($urandom_range(0, 99) < 88) ? $urandom_range(1, 3)
                                                  : $urandom_range(10, 40);
      end
      out_ch.ready <= (stall_left == 0);
      if (stall_left > 0) stall_left--;
    end
  end

  always @(posedge clk) begin : check_results
    packed_byte_t want;
    if (rst_n && out_ch.valid && out_ch.ready) begin
      bytes_checked++;
      if (expected_bytes.size() == 0) begin
        $error("unexpected transfer: out_byte %02h last_byte %0b",
               out_ch.out_byte, out_ch.last_byte);
        fail_count++;
      end else begin
        want = expected_bytes.pop_front();
        if (out_ch.out_byte !== want.data) begin
          $error("out_byte: expected %02h, actual %02h", want.data, out_ch.out_byte);
          fail_count++;
        end
        if (out_ch.last_byte !== want.last) begin
          $error("last_byte: expected %0b, actual %0b", want.last, out_ch.last_byte);
          fail_count++;
        end
      end
    end
  end

  always @(posedge clk) begin
    if (rst_n) begin
      if ((in_ch.valid && in_ch.ready) || (out_ch.valid && out_ch.ready)) begin
        idle_cycles = 0;
      end else begin
        idle_cycles++;
        if (idle_cycles >= WATCHDOG_LIMIT) begin
          $error("no transfer for %0d cycles, %0d results outstanding",
                 idle_cycles, expected_bytes.size());
          $display("CHECKS FAILED");
          $finish;
        end
      end
    end
  end

  initial begin
    rst_n           <= 1'b0;
    in_ch.valid     <= 1'b0;
    in_ch.kind      <= KIND_LOAD;
    in_ch.symbol    <= '0;
    in_ch.code_word <= '0;
    repeat (5) @(posedge clk);
    rst_n <= 1'b1;

    test_reset_state();
    test_edge_codes();
    test_output_holdoff();
    test_random_traffic();

    if (expected_bytes.size() != 0) begin
      $error("%0d expected results never arrived", expected_bytes.size());
      fail_count++;
    end
    $display("Sent %0d loads, %0d encodes, %0d flushes and %0d unused-kind items",
             n_loads, n_encodes, n_flushes, n_ignored);
    $display("Checked %0d packed bytes, incl. a %0d-cycle output stall",
             bytes_checked, HOLDOFF_CYCLES);
    if (fail_count == 0) begin
      $display("ALL CHECKS PASSED");
    end else begin
      $display("CHECKS FAILED");
    end
    $finish;
  end

endmodule

// ----- filelist.f -----
+incdir+hw/rtl
hw/rtl/hcbp_pkg.sv
hw/rtl/hcbp_in_if.sv
hw/rtl/hcbp_out_if.sv
hw/rtl/huffman_code_bit_packer.sv
verif/tb_top.sv
